// ===== rtl/residue_add_normalizer_unit_assert.svh =====
// assertion macros for the residue add normalizer
`ifndef RESIDUE_ADD_NORMALIZER_UNIT_ASSERT_SVH
`define RESIDUE_ADD_NORMALIZER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RANN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("assertion failed");
`define RANN_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error("assertion failed");
`else
`define RANN_ASSERT(lbl, clk, rstn, prop)
`define RANN_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ===== rtl/rann_pkg.sv =====
// shared constants, types and helpers of the residue add normalizer
`default_nettype none
package rann_pkg;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned FRAC      = 30;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned SUM_W     = 38;
  localparam int unsigned FAC_W     = 31;
  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned DEF_VECTOR_LENGTH = 64;

  localparam logic [FAC_W-1:0] ONE_Q = 31'h4000_0000;

  localparam logic MODE_CUT   = 1'b0;
  localparam logic MODE_SCALE = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             mode;
  } job_t;

  typedef struct packed {
    logic [VALUE_W-1:0] res;
    logic [IDX_W-1:0]   idx;
    logic               last;
    logic [CNT_W-1:0]   cnt;
    logic [VALUE_W-1:0] big;
    logic [SUM_W-1:0]   tot;
    logic [FAC_W-1:0]   scale;
    logic               zf;
  } res_t;

  // clamp a 34-bit signed value to the 32-bit signed range
  function automatic logic [VALUE_W-1:0] sat_val(input logic signed [33:0] x);
    if (x > $signed(34'h0_7FFF_FFFF)) begin
      sat_val = 32'h7FFF_FFFF;
    end else if (x < $signed(34'h3_8000_0000)) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = x[31:0];
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/rann_store.sv =====
// element store: base and residue pairs, one write and one registered read port
`default_nettype none
module rann_store #(
  parameter int unsigned VectorLength = rann_pkg::DEF_VECTOR_LENGTH,
  localparam int unsigned AW = (VectorLength > 1) ? $clog2(VectorLength) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                waddr_i,
  input  wire logic [2*rann_pkg::VALUE_W-1:0] wdata_i,
  input  wire logic [AW-1:0]                raddr_i,
  output logic [2*rann_pkg::VALUE_W-1:0]    rdata_o
);
  logic [2*rann_pkg::VALUE_W-1:0] mem_q [VectorLength];
  logic [2*rann_pkg::VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ===== rtl/rann_front.sv =====
// front end: accepts element beats, fills the store and queues a pass per vector
`default_nettype none
module rann_front #(
  parameter int unsigned VectorLength = rann_pkg::DEF_VECTOR_LENGTH,
  localparam int unsigned AW = (VectorLength > 1) ? $clog2(VectorLength) : 1,
  localparam int unsigned CW = $clog2(VectorLength + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire logic [2*rann_pkg::VALUE_W-1:0] data_i,
  input  wire logic                           last_i,
  output logic                                ready_o,
  input  wire logic                           mode_i,
  input  wire logic                           done_i,
  input  wire logic                           full_i,
  output logic                                push_o,
  output rann_pkg::job_t                      job_o,
  output logic                                we_o,
  output logic [AW-1:0]                       waddr_o,
  output logic [2*rann_pkg::VALUE_W-1:0]      wdata_o
);
  logic [CW-1:0] cnt_q, cnt_d, cnt_inc;
  logic          busy_q, busy_d;
  logic          acc, fin;

  assign ready_o = !busy_q && !full_i;
  assign acc     = valid_i && ready_o;
  assign cnt_inc = cnt_q + CW'(1);
  // full store closes the vector as if marked last
  assign fin     = last_i || (cnt_inc == CW'(VectorLength));

  assign we_o       = acc;
  assign waddr_o    = cnt_q[AW-1:0];
  assign wdata_o    = data_i;
  assign push_o     = acc && fin;
  assign job_o.n    = rann_pkg::CNT_W'(cnt_inc);
  assign job_o.mode = mode_i;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (acc) begin
      if (fin) begin
        cnt_d  = '0;
        busy_d = 1'b1;
      end else begin
        cnt_d = cnt_inc;
      end
    end
    if (done_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rann_fifo.sv =====
// short job queue between front and back
`default_nettype none
module rann_fifo (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire rann_pkg::job_t data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output rann_pkg::job_t data_o
);
  localparam int unsigned PW = $clog2(rann_pkg::JOB_DEPTH);
  localparam int unsigned NW = $clog2(rann_pkg::JOB_DEPTH + 1);

  rann_pkg::job_t ent_q [rann_pkg::JOB_DEPTH];
  logic [PW-1:0]  wp_q, rp_q;
  logic [NW-1:0]  num_q;

  assign full_o  = (num_q == NW'(rann_pkg::JOB_DEPTH));
  assign valid_o = (num_q != '0);
  assign data_o  = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      num_q <= '0;
    end else begin
      if (push_i) wp_q <= PW'(wp_q + PW'(1));
      if (pop_i)  rp_q <= PW'(rp_q + PW'(1));
      num_q <= NW'(num_q + NW'(push_i) - NW'(pop_i));
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rann_div.sv =====
// bit-serial fraction divider: num * 2^30 / den, capped at 2^30 when num >= den, one quotient bit a cycle
`default_nettype none
module rann_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [rann_pkg::SUM_W-1:0]   num_i,
  input  wire logic [rann_pkg::SUM_W-1:0]   den_i,
  input  wire logic                         rnd_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [rann_pkg::FAC_W-1:0]        quot_o
);
  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_RND  = 2'd2;
  localparam logic [1:0] D_DONE = 2'd3;

  logic [1:0]                   st_q;
  logic [4:0]                   step_q;
  logic [rann_pkg::SUM_W-1:0]   rem_q, den_q;
  logic [rann_pkg::FAC_W-1:0]   quo_q;
  logic                         rnd_q;
  logic [rann_pkg::SUM_W:0]     rem2;
  logic                         ge;

  assign rem2   = {rem_q, 1'b0};
  assign ge     = rem2 >= {1'b0, den_q};
  assign busy_o = (st_q != D_IDLE);
  assign done_o = (st_q == D_DONE);
  assign quot_o = quo_q;

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      D_IDLE: begin
        if (start_i) begin
          rem_q <= num_i;
          den_q <= den_i;
          rnd_q <= rnd_i;
          quo_q <= (num_i >= den_i) ? rann_pkg::ONE_Q : '0;
        end
      end
      D_RUN: begin
        rem_q <= ge ? rann_pkg::SUM_W'(rem2 - {1'b0, den_q}) : rem2[rann_pkg::SUM_W-1:0];
        quo_q <= {quo_q[rann_pkg::FAC_W-2:0], ge};
      end
      D_RND: begin
        if (rnd_q && ge) quo_q <= quo_q + rann_pkg::FAC_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      step_q <= '0;
    end else begin
      unique case (st_q)
        D_IDLE: begin
          if (start_i) begin
            step_q <= '0;
            st_q   <= (num_i >= den_i) ? D_DONE : D_RUN;
          end
        end
        D_RUN: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'(rann_pkg::FRAC - 1)) st_q <= D_RND;
        end
        D_RND:   st_q <= D_DONE;
        default: st_q <= D_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rann_back.sv =====
// back end: sweeps the stored vector, gathers statistics and emits results
`default_nettype none
module rann_back #(
  parameter int unsigned VectorLength = rann_pkg::DEF_VECTOR_LENGTH,
  localparam int unsigned AW = (VectorLength > 1) ? $clog2(VectorLength) : 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           job_valid_i,
  input  wire rann_pkg::job_t                 job_i,
  output logic                                job_pop_o,
  output logic [AW-1:0]                       raddr_o,
  input  wire logic [2*rann_pkg::VALUE_W-1:0] rdata_i,
  output logic                                div_start_o,
  output logic [rann_pkg::SUM_W-1:0]          div_num_o,
  output logic [rann_pkg::SUM_W-1:0]          div_den_o,
  output logic                                div_rnd_o,
  input  wire logic                           div_done_i,
  input  wire logic [rann_pkg::FAC_W-1:0]     div_quot_i,
  output logic                                res_valid_o,
  input  wire logic                           res_ready_i,
  output rann_pkg::res_t                      res_o,
  output logic                                done_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic signed [32:0] ONE33 = 33'sh0_4000_0000;

  logic [2:0]                    st_q;
  logic                          ph_q, mode_q, ov_q;
  logic [AW-1:0]                 k_q;
  logic [rann_pkg::CNT_W-1:0]    n_q, cnt_q;
  logic [rann_pkg::SUM_W-1:0]    sum_q, tot_q;
  logic [rann_pkg::VALUE_W-1:0]  big_q, val_q;
  logic [rann_pkg::FAC_W-1:0]    f_q;
  logic [62:0]                   prod_q;
  rann_pkg::res_t                res_q;

  logic signed [32:0] b_s, r_s, sum_w;
  logic [31:0]        ssat, clip_w, mag_w, rabs;
  logic [32:0]        neg33, rneg, ob;
  logic [38:0]        tot_add, sum_add;
  logic [62:0]        prod_w, prnd;
  logic [32:0]        tmag;
  logic [33:0]        ts, bt;
  logic               last_k, lo, hi, help_lo, help_hi, out_free;

  assign raddr_o = k_q;
  assign b_s     = {rdata_i[31], rdata_i[31:0]};
  assign r_s     = {rdata_i[63], rdata_i[63:32]};
  assign sum_w   = b_s + r_s;
  assign ssat    = rann_pkg::sat_val({sum_w[32], sum_w});
  assign clip_w  = ssat[31] ? '0 : ssat;
  assign neg33   = 33'd0 - {ssat[31], ssat};
  assign mag_w   = neg33[31:0];
  assign tot_add = {1'b0, tot_q} + 39'(mag_w);
  assign sum_add = {1'b0, sum_q} + 39'(clip_w);

  // factor search terms
  assign lo      = sum_w[32];
  assign hi      = sum_w > ONE33;
  assign rneg    = 33'd0 - r_s;
  assign ob      = 33'h0_4000_0000 - b_s;
  assign help_lo = !b_s[32] && r_s[32];
  assign help_hi = (b_s <= ONE33) && !r_s[32] && (r_s != '0);

  // scaled residue, magnitude rounded half away from zero
  assign rabs   = r_s[32] ? rneg[31:0] : rdata_i[63:32];
  assign prod_w = rabs * f_q;
  assign prnd   = prod_q + 63'h2000_0000;
  assign tmag   = prnd[62:30];
  assign ts     = r_s[32] ? (34'd0 - {1'b0, tmag}) : {1'b0, tmag};
  assign bt     = {b_s[32], b_s} + ts;

  assign last_k   = (rann_pkg::CNT_W'(k_q) + rann_pkg::CNT_W'(1)) == n_q;
  assign out_free = !ov_q || res_ready_i;

  always_comb begin
    div_start_o = 1'b0;
    div_num_o   = '0;
    div_den_o   = '0;
    div_rnd_o   = 1'b0;
    if (st_q == S_EV) begin
      if (!ph_q && mode_q == rann_pkg::MODE_SCALE) begin
        if (lo && help_lo) begin
          div_start_o = 1'b1;
          div_num_o   = rann_pkg::SUM_W'(b_s[31:0]);
          div_den_o   = rann_pkg::SUM_W'(rneg[31:0]);
        end else if (!lo && hi && help_hi) begin
          div_start_o = 1'b1;
          div_num_o   = rann_pkg::SUM_W'(ob);
          div_den_o   = rann_pkg::SUM_W'(r_s[31:0]);
        end
      end else if (ph_q && mode_q == rann_pkg::MODE_CUT && sum_q != '0) begin
        div_start_o = 1'b1;
        div_num_o   = rann_pkg::SUM_W'(clip_w);
        div_den_o   = sum_q;
        div_rnd_o   = 1'b1;
      end
    end
  end

  assign job_pop_o   = (st_q == S_IDLE) && job_valid_i;
  assign done_o      = (st_q == S_OUT) && out_free && last_k;
  assign res_valid_o = ov_q;
  assign res_o       = res_q;

  // result fields
  always_ff @(posedge clk_i) begin
    if (st_q == S_OUT && out_free) begin
      res_q.res   <= val_q;
      res_q.idx   <= rann_pkg::IDX_W'(k_q);
      res_q.last  <= last_k;
      res_q.cnt   <= cnt_q;
      res_q.big   <= big_q;
      res_q.tot   <= tot_q;
      res_q.scale <= (mode_q == rann_pkg::MODE_SCALE) ? f_q : '0;
      res_q.zf    <= (mode_q == rann_pkg::MODE_CUT) && (sum_q == '0);
    end
    if (st_q == S_EV) prod_q <= prod_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ph_q   <= 1'b0;
      mode_q <= rann_pkg::MODE_CUT;
      ov_q   <= 1'b0;
      k_q    <= '0;
      n_q    <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      tot_q  <= '0;
      big_q  <= '0;
      val_q  <= '0;
      f_q    <= rann_pkg::ONE_Q;
    end else begin
      // output register fills on a new beat, empties when taken
      if (st_q == S_OUT && out_free) begin
        ov_q <= 1'b1;
      end else if (res_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (job_valid_i) begin
            n_q    <= job_i.n;
            mode_q <= job_i.mode;
            ph_q   <= 1'b0;
            k_q    <= '0;
            cnt_q  <= '0;
            sum_q  <= '0;
            tot_q  <= '0;
            big_q  <= '0;
            f_q    <= rann_pkg::ONE_Q;
            st_q   <= S_RD;
          end
        end
        S_RD: st_q <= S_EV;
        S_EV: begin
          if (!ph_q) begin
            if (mode_q == rann_pkg::MODE_CUT) begin
              if (ssat[31]) begin
                cnt_q <= cnt_q + rann_pkg::CNT_W'(1);
                if (mag_w > big_q) big_q <= mag_w;
                tot_q <= tot_add[38] ? '1 : tot_add[37:0];
              end
              sum_q <= sum_add[38] ? '1 : sum_add[37:0];
            end else if (lo || hi) begin
              // out of bounds with no helping residue pins the factor to zero
              if (!div_start_o) f_q <= '0;
            end
            if (div_start_o) begin
              st_q <= S_DIV;
            end else begin
              st_q <= S_RD;
              ph_q <= last_k;
              k_q  <= last_k ? '0 : AW'(k_q + AW'(1));
            end
          end else if (mode_q == rann_pkg::MODE_CUT) begin
            if (div_start_o) begin
              st_q <= S_DIV;
            end else begin
              val_q <= clip_w;
              st_q  <= S_OUT;
            end
          end else begin
            st_q <= S_MUL;
          end
        end
        S_DIV: begin
          if (div_done_i) begin
            if (!ph_q) begin
              if (div_quot_i < f_q) f_q <= div_quot_i;
              st_q <= S_RD;
              ph_q <= last_k;
              k_q  <= last_k ? '0 : AW'(k_q + AW'(1));
            end else begin
              val_q <= rann_pkg::VALUE_W'(div_quot_i);
              st_q  <= S_OUT;
            end
          end
        end
        S_MUL: begin
          val_q <= rann_pkg::sat_val(bt);
          st_q  <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (last_k) begin
              st_q <= S_IDLE;
            end else begin
              k_q  <= AW'(k_q + AW'(1));
              st_q <= S_RD;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/residue_add_normalizer_unit.sv =====
// Residue add normalizer. Element beats (base and residue, signed Q2.30) load one per
// cycle while tready is high into a 64-entry store; a beat with tlast set, or the beat
// that fills the store, closes the vector and queues one pass. The pass emits one result
// beat per element in index order. Cut mode (combine_mode 0) first reads and evaluates
// each element to sum, clip and gather statistics, then scales each element by the sum
// in the shared bit-serial divider (one quotient bit a cycle, 30 steps); a zero sum
// skips the division and raises the flag in tuser. Scale mode (combine_mode 1) first
// searches the factor, reading and evaluating each element and dividing only for an
// element out of bounds that has a helping residue, then emits base plus scaled residue
// per element through a read, evaluate, multiply and output state. Loading of the next
// vector waits until the last result of the current pass has been placed in the output
// register. The store is not cleared after reset. Write combine_mode only while the block is idle.
`default_nettype none
`include "residue_add_normalizer_unit_assert.svh"
module residue_add_normalizer_unit #(
  parameter int unsigned VECTOR_LENGTH = rann_pkg::DEF_VECTOR_LENGTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // config: combine_mode
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  // element beats
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [63:0]   s_axis_tdata_i,   // base_value, residue_value
  input  wire logic          s_axis_tlast_i,   // last_element
  // result beats
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  // result_value, element_index, cut_count, largest_cut, cut sum, scale_used, zero pad
  output logic [151:0]       m_axis_tdata_o,
  output logic               m_axis_tlast_o,   // end_of_vector
  output logic               m_axis_tuser_o    // zero_sum_flag
);
  localparam int unsigned AW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;

  logic                       mode_q;
  logic                       push, full, pop, job_valid, done;
  rann_pkg::job_t             job_in, job_out;
  logic                       we;
  logic [AW-1:0]              waddr, raddr;
  logic [63:0]                wdata, rdata;
  logic                       div_start, div_rnd, div_busy, div_done;
  logic [rann_pkg::SUM_W-1:0] div_num, div_den;
  logic [rann_pkg::FAC_W-1:0] div_quot;
  rann_pkg::res_t             res;

  // combine mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rann_pkg::MODE_CUT;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  rann_front #(.VectorLength(VECTOR_LENGTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .data_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .ready_o (s_axis_tready_o),
    .mode_i  (mode_q),
    .done_i  (done),
    .full_i  (full),
    .push_o  (push),
    .job_o   (job_in),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata)
  );

  rann_store #(.VectorLength(VECTOR_LENGTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // queue of closed vectors waiting for the back end
  rann_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  rann_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .rnd_i   (div_rnd),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  rann_back #(.VectorLength(VECTOR_LENGTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (pop),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .div_start_o (div_start),
    .div_num_o   (div_num),
    .div_den_o   (div_den),
    .div_rnd_o   (div_rnd),
    .div_done_i  (div_done),
    .div_quot_i  (div_quot),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res),
    .done_o      (done)
  );

  // pack result beat
  assign m_axis_tdata_o = {6'd0, res.scale, res.tot, res.big, res.cnt, res.idx, res.res};
  assign m_axis_tlast_o = res.last;
  assign m_axis_tuser_o = res.zf;

  // queue never overflows or underflows, divider is never restarted mid-run, input stalls once a vector closes
  `RANN_ASSERT(a_push_room, clk_i, rst_ni, push |-> !full)
  `RANN_ASSERT(a_pop_valid, clk_i, rst_ni, pop |-> job_valid)
  `RANN_ASSERT_NEVER(a_div_restart, clk_i, rst_ni, div_start && div_busy)
  `RANN_ASSERT(a_no_load_in_pass, clk_i, rst_ni, push |=> !s_axis_tready_o)
endmodule
`default_nettype wire
